// ===== hw/rtl/cll_pkg.sv =====
// Shared types and constants for the cursor linked list.
`default_nettype none

package cll_pkg;

    // Default sizing
    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed width of the value ports
    localparam int PORT_W = 32;

    // Cells per group in the first level of the readout tree
    localparam int GROUP_SIZE = 8;

    // Command codes
    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_START  = 3'd3,
        CMD_NEXT   = 3'd4
    } cmd_t;

    // Per-cell action, broadcast along the row
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    // Control bundle seen by every cell
    typedef struct packed {
        cell_op_t op;
        logic     read_en;
    } cell_ctl_t;

    // Command sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROUP,
        ST_FINISH
    } seq_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cll_cell.sv =====
// One list position: holds an entry value and trades it with its neighbors.
`default_nettype none

module cll_cell #(
    parameter int IDX_W       = $clog2(cll_pkg::CAPACITY_DEF),
    parameter int VALUE_WIDTH = cll_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire cll_pkg::cell_ctl_t     ctl,
    input  wire logic [IDX_W-1:0]       index,
    input  wire logic [IDX_W-1:0]       anchor,
    input  wire logic [IDX_W-1:0]       cursor,
    input  wire logic [VALUE_WIDTH-1:0] load_value,
    input  wire logic [VALUE_WIDTH-1:0] left_value,
    input  wire logic [VALUE_WIDTH-1:0] right_value,
    output logic      [VALUE_WIDTH-1:0] value,
    output logic      [VALUE_WIDTH-1:0] read_value
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   at_anchor;
    logic                   past_anchor;

    assign at_anchor   = (index == anchor);
    assign past_anchor = (index > anchor);

    // Position update: load, open a gap (insert) or close one (remove)
    always_comb
    begin
        value_next = value_reg;
        case (ctl.op)
            cll_pkg::CELL_APPEND:
            begin
                if (at_anchor)
                    value_next = load_value;
            end
            cll_pkg::CELL_INSERT:
            begin
                if (at_anchor)
                    value_next = load_value;
                else if (past_anchor)
                    value_next = left_value;
            end
            cll_pkg::CELL_REMOVE:
            begin
                if (at_anchor || past_anchor)
                    value_next = right_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

    // Only the cursor cell drives the readout tree
    assign read_value = (ctl.read_en && (index == cursor)) ? value_reg : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/cll_gather.sv =====
// Registered OR tree that collects the cursor cell's value from the row.
`default_nettype none

module cll_gather #(
    parameter int CAPACITY    = cll_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = cll_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic [VALUE_WIDTH-1:0] cell_values [CAPACITY],
    output logic      [VALUE_WIDTH-1:0] merged
);

    localparam int GS = cll_pkg::GROUP_SIZE;
    localparam int NG = (CAPACITY + GS - 1) / GS;

    logic [VALUE_WIDTH-1:0] padded   [NG*GS];
    logic [VALUE_WIDTH-1:0] grp_next [NG];
    logic [VALUE_WIDTH-1:0] grp_reg  [NG];

    // Pad the row out to whole groups
    for (genvar i = 0; i < NG*GS; i++)
    begin : g_pad
        if (i < CAPACITY)
        begin : g_real
            assign padded[i] = cell_values[i];
        end
        else
        begin : g_zero
            assign padded[i] = '0;
        end
    end

    // First level: one OR per group, registered
    for (genvar g = 0; g < NG; g++)
    begin : g_group
        always_comb
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GS; k++)
            begin
                grp_next[g] = grp_next[g] | padded[g*GS + k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    // Second level: OR of group results
    always_comb
    begin
        merged = '0;
        for (int g = 0; g < NG; g++)
        begin
            merged = merged | grp_reg[g];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cursor_linked_list.sv =====
// Top level of the cursor linked list: command sequencer, cell row and readout.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  command | in        | cmd_valid, cmd_stall | cmd, item_value
//  result  | out       | res_valid, res_stall | value_out, found, dropped, length
//
// Each command updates the list in the cycle of the transfer; in ST_GROUP the
// cursor cell's value crosses the registered OR tree, and ST_FINISH loads it into
// the result registers. That path does not depend on the list length.
// Reset clears the control state only; entry values hold nothing until written.
// A stalled result holds the sequencer in its last step; one more command can be
// taken and updated while the previous result still waits.
`default_nettype none

module cursor_linked_list #(
    parameter int CAPACITY    = cll_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = cll_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_stall,
    input  wire logic [2:0]                    cmd,
    input  wire logic [cll_pkg::PORT_W-1:0]    item_value,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output logic      [cll_pkg::PORT_W-1:0]    value_out,
    output logic                               found,
    output logic                               dropped,
    output logic      [$clog2(CAPACITY+1)-1:0] length
);

    localparam int IW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int PW = cll_pkg::PORT_W;

    cll_pkg::seq_state_t state_reg, state_next;

    logic [LW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic          cur_valid_reg, cur_valid_next;
    logic          pend_found_reg, pend_found_next;
    logic          pend_dropped_reg, pend_dropped_next;

    logic          res_valid_reg;
    logic [PW-1:0] value_out_reg;
    logic          found_reg;
    logic          dropped_reg;
    logic [LW-1:0] length_reg;

    logic               accept;
    logic               load_out;
    logic               full;
    logic               empty;
    logic               single;
    logic               append_path;
    cll_pkg::cell_op_t  op_c;
    cll_pkg::cell_ctl_t cell_ctl;
    logic [IW-1:0]      anchor;
    logic               found_c;
    logic               dropped_c;

    logic [VALUE_WIDTH-1:0] in_value;
    logic [VALUE_WIDTH-1:0] merged;
    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [VALUE_WIDTH-1:0] read_value [CAPACITY];

    assign accept   = cmd_valid && !cmd_stall;
    assign full     = (cnt_reg == LW'(CAPACITY));
    assign empty    = (cnt_reg == '0);
    assign single   = (cnt_reg == LW'(1));
    assign in_value = VALUE_WIDTH'(item_value);

    // Insert with no cursor or into an empty list behaves as append
    assign append_path = (cmd == cll_pkg::CMD_APPEND) ||
                         ((cmd == cll_pkg::CMD_INSERT) && (empty || !cur_valid_reg));

    // Command decode: new count, cursor and cell action
    always_comb
    begin
        cnt_next          = cnt_reg;
        pos_next          = pos_reg;
        cur_valid_next    = cur_valid_reg;
        op_c              = cll_pkg::CELL_HOLD;
        anchor            = pos_reg;
        found_c           = 1'b0;
        dropped_c         = 1'b0;
        if (append_path)
        begin
            if (full)
                dropped_c = 1'b1;
            else
            begin
                op_c           = cll_pkg::CELL_APPEND;
                anchor         = IW'(cnt_reg);
                cnt_next       = cnt_reg + LW'(1);
                pos_next       = IW'(cnt_reg);
                cur_valid_next = 1'b1;
            end
        end
        else
        begin
            case (cmd)
                cll_pkg::CMD_INSERT:
                begin
                    if (full)
                        dropped_c = 1'b1;
                    else
                    begin
                        op_c     = cll_pkg::CELL_INSERT;
                        cnt_next = cnt_reg + LW'(1);
                    end
                end
                cll_pkg::CMD_REMOVE:
                begin
                    if (single)
                    begin
                        cnt_next       = '0;
                        cur_valid_next = 1'b0;
                    end
                    else if (!empty && cur_valid_reg)
                    begin
                        op_c     = cll_pkg::CELL_REMOVE;
                        cnt_next = cnt_reg - LW'(1);
                        // cursor falls back to the predecessor, or stays on the new head
                        if (pos_reg != '0)
                            pos_next = pos_reg - IW'(1);
                    end
                end
                cll_pkg::CMD_START:
                begin
                    if (empty)
                        cur_valid_next = 1'b0;
                    else
                    begin
                        pos_next       = '0;
                        cur_valid_next = 1'b1;
                        found_c        = 1'b1;
                    end
                end
                cll_pkg::CMD_NEXT:
                begin
                    if (cur_valid_reg && ((LW'(pos_reg) + LW'(1)) < cnt_reg))
                    begin
                        pos_next = pos_reg + IW'(1);
                        found_c  = 1'b1;
                    end
                end
                default:
                begin
                    op_c = cll_pkg::CELL_HOLD;
                end
            endcase
        end
    end

    assign cell_ctl.op      = accept ? op_c : cll_pkg::CELL_HOLD;
    assign cell_ctl.read_en = cur_valid_reg;

    assign pend_found_next   = accept ? found_c   : pend_found_reg;
    assign pend_dropped_next = accept ? dropped_c : pend_dropped_reg;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cll_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = cll_pkg::ST_GROUP;
            end
            cll_pkg::ST_GROUP:
            begin
                state_next = cll_pkg::ST_FINISH;
            end
            cll_pkg::ST_FINISH:
            begin
                if (load_out)
                    state_next = cll_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cll_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        cmd_stall = 1'b1;
        load_out  = 1'b0;
        case (state_reg)
            cll_pkg::ST_IDLE:
            begin
                cmd_stall = 1'b0;
            end
            cll_pkg::ST_FINISH:
            begin
                load_out = !res_valid_reg || !res_stall;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cll_pkg::ST_IDLE;
            cnt_reg          <= '0;
            pos_reg          <= '0;
            cur_valid_reg    <= 1'b0;
            pend_found_reg   <= 1'b0;
            pend_dropped_reg <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pend_found_reg   <= pend_found_next;
            pend_dropped_reg <= pend_dropped_next;
            if (accept)
            begin
                cnt_reg       <= cnt_next;
                pos_reg       <= pos_next;
                cur_valid_reg <= cur_valid_next;
            end
            if (load_out)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            value_out_reg <= pend_found_reg ? PW'(merged) : '0;
            found_reg     <= pend_found_reg;
            dropped_reg   <= pend_dropped_reg;
            length_reg    <= cnt_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign value_out = value_out_reg;
    assign found     = found_reg;
    assign dropped   = dropped_reg;
    assign length    = length_reg;

    // Row of list cells, position 0 is the head
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_value;
        logic [VALUE_WIDTH-1:0] right_value;

        if (i == 0)
        begin : g_first
            assign left_value = cell_value[i];
        end
        else
        begin : g_left
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_right
            assign right_value = cell_value[i+1];
        end

        cll_cell #(
            .IDX_W       (IW),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk         (clk),
            .ctl         (cell_ctl),
            .index       (IW'(i)),
            .anchor      (anchor),
            .cursor      (pos_reg),
            .load_value  (in_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .read_value  (read_value[i])
        );
    end

    cll_gather #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_gather (
        .clk         (clk),
        .cell_values (read_value),
        .merged      (merged)
    );

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LW'(CAPACITY))
        else $error("entry count above capacity");

    a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (LW'(pos_reg) < cnt_reg))
        else $error("cursor points past the tail");

    a_empty_no_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> !cur_valid_reg)
        else $error("cursor set on an empty list");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == cll_pkg::CMD_APPEND) && (cnt_reg != LW'(CAPACITY)))
        |=> (cnt_reg == $past(cnt_reg) + LW'(1)))
        else $error("append did not grow the list");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == cll_pkg::ST_FINISH))
        else $error("result raised outside the finish step");

endmodule

`default_nettype wire
